[rtl/sha256_pow_nonce_checker_macros.svh]
// Assertion macros of the nonce checker RTL.
`ifndef SHA256_POW_NONCE_CHECKER_MACROS_SVH
`define SHA256_POW_NONCE_CHECKER_MACROS_SVH
`ifndef SYNTH
// Clocked check that is switched off while reset is high.
`define SPN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spn assertion failed");
// Clocked check that also watches the reset cycles.
`define SPN_ASSERT_ANY(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("spn assertion failed");
`else
`define SPN_ASSERT(lbl, clk, rst, prop)
`define SPN_ASSERT_ANY(lbl, clk, prop)
`endif
`endif

[rtl/spn_pkg.sv]
// Types, constants and hash helper functions of the nonce checker.
package spn_pkg;

   // Eight hash words, word 0 (a or h0) leftmost.
   typedef logic [0:7][31:0] word8_type;
   // Sixteen message words, word 0 leftmost.
   typedef logic [0:15][31:0] blk_type;

   // What travels with a nonce: the nonce and its decimal digits, lowest first.
   typedef struct packed {
      logic [23:0]      nonce;
      logic [7:0][3:0]  digits;
      logic [3:0]       nd;
   } tag_type;

   // One word of the decimal digit chain.
   typedef struct packed {
      tag_type     tag;
      logic [23:0] rest;
   } dec_type;

   // One word of the round chain.
   typedef struct packed {
      word8_type st;
      blk_type   win;
      word8_type hash;
      tag_type   tag;
   } round_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TARGET = 3'd0;
   localparam logic [2:0] CSR_BODY0  = 3'd1;
   localparam logic [2:0] CSR_BODY1  = 3'd2;
   localparam logic [2:0] CSR_BODY2  = 3'd3;
   localparam logic [2:0] CSR_BODY3  = 3'd4;
   localparam logic [2:0] CSR_BODY4  = 3'd5;
   localparam logic [2:0] CSR_BODY5  = 3'd6;

   localparam logic [6:0] TARGET_RESET = 7'd16;

   // Message constants.
   localparam logic [103:0] DOMAIN_TAG   = 104'h47454D49583A506F573A76313A;
   localparam logic [95:0]  CODON_HEADER = "ATGGGGTGGTGC";
   localparam logic [31:0]  TAA_BAR      = "TAA|";
   localparam logic [215:0] MIX_SEED     =
      216'h67656D69782F646E613235362F646973706C61792D6D69782F7631;

   // Three letters for each of the 64 codon values.
   localparam logic [1535:0] CODON_TAB = {
      "TTTTTATTCTTGTATGCTTACGCT", "TCTTCATCCTCGTGTGCTTGCTGG",
      "ATTATAATCGCTAATAAAAACAAG", "ACTACAACCACGAGTAGAAGCAGG",
      "CTTCTACTCCTGCATCAACACCAG", "CCTCCACCCCCGCGTCGACGCCGG",
      "GTTGTAGTCGTGGATGAAGACGAG", "GCTGCAGCCGCGGGTGGAGGCGGG"};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam word8_type INIT_H = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   // Letters of one codon value.
   function automatic logic [23:0] codon_letters(input logic [5:0] v);
      return CODON_TAB[1535 - 24 * int'(v) -: 24];
   endfunction

   // Full compression of one block; evaluated only at elaboration.
   function automatic word8_type sha_compress(input word8_type hin, input blk_type blk);
      logic [31:0] w [64];
      word8_type   s;
      word8_type   r;
      logic [31:0] t1;
      logic [31:0] t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = blk[i];
      end
      for (int i = 16; i < 64; i++) begin
         w[i] = ssig1(w[i-2]) + w[i-7] + ssig0(w[i-15]) + w[i-16];
      end
      s = hin;
      for (int i = 0; i < 64; i++) begin
         t1 = s[7] + bsig1(s[4]) + choose(s[4], s[5], s[6]) + ROUND_K[i] + w[i];
         t2 = bsig0(s[0]) + major(s[0], s[1], s[2]);
         s[7] = s[6];
         s[6] = s[5];
         s[5] = s[4];
         s[4] = s[3] + t1;
         s[3] = s[2];
         s[2] = s[1];
         s[1] = s[0];
         s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
         r[i] = hin[i] + s[i];
      end
      return r;
   endfunction

   // Digest of the seed string, used to mask every result.
   localparam blk_type   SEED_BLOCK = {MIX_SEED, 8'h80, 224'd0, 64'd216};
   localparam word8_type MIX_MASK   = sha_compress(INIT_H, SEED_BLOCK);

endpackage

[rtl/spn_dec_cell.sv]
// One cell of the decimal digit chain: peels off one digit per cell.
module spn_dec_cell #(
   parameter int DIGIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  spn_pkg::dec_type in_data,
   output logic             out_valid,
   output spn_pkg::dec_type out_data
);
   import spn_pkg::*;

   logic        valid_ff;
   dec_type     data_ff;
   dec_type     data_in;
   logic [47:0] prod;
   logic [20:0] quot;
   logic [23:0] back;

   // Divide by ten through the reciprocal, exact for 24-bit values.
   always_comb begin
      prod = in_data.rest * 24'd13421773;
      quot = prod[47:27];
      back = {3'b000, quot} * 24'd10;
      data_in = in_data;
      data_in.tag.digits[DIGIT] = 4'(in_data.rest - back);
      if (DIGIT == 0 || in_data.rest != 24'd0) begin
         data_in.tag.nd = 4'(DIGIT + 1);
      end
      data_in.rest = {3'b000, quot};
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

[rtl/spn_round_cell.sv]
// One SHA-256 round cell: state update plus one step of the message schedule.
module spn_round_cell #(
   parameter int ROUND = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  spn_pkg::round_type in_data,
   output logic               out_valid,
   output spn_pkg::round_type out_data
);
   import spn_pkg::*;

   logic        valid_ff;
   round_type   data_ff;
   round_type   data_in;
   logic [31:0] t1;
   logic [31:0] t2;

   // Round function and window shift.
   always_comb begin
      t1 = in_data.st[7] + bsig1(in_data.st[4])
         + choose(in_data.st[4], in_data.st[5], in_data.st[6])
         + ROUND_K[ROUND] + in_data.win[0];
      t2 = bsig0(in_data.st[0]) + major(in_data.st[0], in_data.st[1], in_data.st[2]);
      data_in = in_data;
      data_in.st[0] = t1 + t2;
      data_in.st[1] = in_data.st[0];
      data_in.st[2] = in_data.st[1];
      data_in.st[3] = in_data.st[2];
      data_in.st[4] = in_data.st[3] + t1;
      data_in.st[5] = in_data.st[4];
      data_in.st[6] = in_data.st[5];
      data_in.st[7] = in_data.st[6];
      for (int i = 0; i < 15; i++) begin
         data_in.win[i] = in_data.win[i+1];
      end
      data_in.win[15] = in_data.win[0] + ssig0(in_data.win[1]) + in_data.win[9]
                      + ssig1(in_data.win[14]);
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

[rtl/spn_block.sv]
// One compressed block: 64 round cells in a row and the chaining add.
module spn_block (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  spn_pkg::tag_type   in_tag,
   input  spn_pkg::word8_type in_hash,
   input  spn_pkg::blk_type   in_block,
   output logic               out_valid,
   output spn_pkg::tag_type   out_tag,
   output spn_pkg::word8_type out_hash
);
   import spn_pkg::*;

   logic      cell_valid [65];
   round_type cell_data  [65];
   logic      valid_ff;
   tag_type   tag_ff;
   word8_type hash_ff;
   word8_type hash_in;

   // The first cell starts from the chaining value and the message words.
   assign cell_valid[0]     = in_valid;
   assign cell_data[0].st   = in_hash;
   assign cell_data[0].win  = in_block;
   assign cell_data[0].hash = in_hash;
   assign cell_data[0].tag  = in_tag;

   for (genvar r = 0; r < 64; r++) begin : g_round
      spn_round_cell #(.ROUND(r)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cell_valid[r]),
         .in_data   (cell_data[r]),
         .out_valid (cell_valid[r+1]),
         .out_data  (cell_data[r+1])
      );
   end

   // Add the working state back into the chaining value.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hash_in[i] = cell_data[64].hash[i] + cell_data[64].st[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= cell_valid[64];
      end
      if (en) begin
         tag_ff  <= cell_data[64].tag;
         hash_ff <= hash_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_hash  = hash_ff;
endmodule

[rtl/sha256_pow_nonce_checker.sv]
// Top level of the SHA-256 proof-of-work nonce checker.
// Takes one nonce word per cycle while the chain is not halted and returns one result
// word per nonce, in order. Each nonce runs through 8 decimal digit cells, four unrolled
// SHA-256 blocks of 64 round cells plus one chaining stage each, one leading-zero stage
// and the output register. The whole chain moves together; it halts only while a result
// waits in the output register and the sink does not take it. The body and target
// registers must be written while no nonce is in flight.
`include "sha256_pow_nonce_checker_macros.svh"
module sha256_pow_nonce_checker (
   input  logic        clock,
   input  logic        reset,
   // Nonce words. req_tdata: [23:0] trial_nonce.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // Result words. rsp_tdata: [23:0] echoed_nonce, [31:24] lead_zeros,
   // [32] is_hit, [39:33] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_data
);
   import spn_pkg::*;

   logic [6:0]  target_ff;
   logic [59:0] body_ff [6];

   logic        en;
   logic        dec_valid [9];
   dec_type     dec_data  [9];

   logic        blk_valid [5];
   tag_type     blk_tag   [5];
   word8_type   blk_hash  [5];
   blk_type     blk_msg   [4];

   logic [1639:0] prefix;
   logic [407:0]  tail;
   logic [3:0]    cod_len;
   logic [119:0]  cod_bytes;
   logic [7:0]    msg_len;

   logic        a_valid_ff;
   logic [23:0] a_nonce_ff;
   logic [5:0]  a_cnt_ff [8];
   logic [5:0]  a_cnt_in [8];
   word8_type   masked;

   logic [8:0]  total;
   logic        found;
   logic [7:0]  lts;

   logic        out_valid_ff;
   logic [23:0] out_nonce_ff;
   logic [7:0]  out_lts_ff;
   logic        out_hit_ff;

   // The chain advances unless a finished result is held back.
   assign en         = !(out_valid_ff && !rsp_tready);
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         for (int i = 0; i < 6; i++) begin
            body_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET: target_ff  <= csr_data[6:0];
            CSR_BODY0:  body_ff[0] <= csr_data;
            CSR_BODY1:  body_ff[1] <= csr_data;
            CSR_BODY2:  body_ff[2] <= csr_data;
            CSR_BODY3:  body_ff[3] <= csr_data;
            CSR_BODY4:  body_ff[4] <= csr_data;
            CSR_BODY5:  body_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   // Decimal digit chain.
   assign dec_valid[0]           = req_tvalid;
   assign dec_data[0].tag.nonce  = req_tdata;
   assign dec_data[0].tag.digits = '0;
   assign dec_data[0].tag.nd     = 4'd0;
   assign dec_data[0].rest       = req_tdata;

   for (genvar d = 0; d < 8; d++) begin : g_dec
      spn_dec_cell #(.DIGIT(d)) u_dec (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dec_valid[d]),
         .in_data   (dec_data[d]),
         .out_valid (dec_valid[d+1]),
         .out_data  (dec_data[d+1])
      );
   end

   // Fixed message prefix: domain tag, codon header and the 60 body codons.
   always_comb begin
      prefix = '0;
      prefix[1639 -: 104] = DOMAIN_TAG;
      prefix[1535 -: 96]  = CODON_HEADER;
      for (int i = 0; i < 60; i++) begin
         prefix[1439 - 24*i -: 24] = codon_letters(body_ff[i/10][6*(i%10) +: 6]);
      end
   end

   // Last block: nonce codons, separator, decimal digits, padding and length.
   always_comb begin
      logic [5:0] off;
      logic [3:0] m;
      logic [3:0] di;
      logic [23:0] nn;
      nn = blk_tag[3].nonce;
      if (nn <= 24'd4094) begin
         cod_len = 4'd6;
      end else if (nn <= 24'd262142) begin
         cod_len = 4'd9;
      end else if (nn <= 24'd16777214) begin
         cod_len = 4'd12;
      end else begin
         cod_len = 4'd15;
      end
      for (int k = 0; k < 4; k++) begin
         cod_bytes[119 - 24*k -: 24] = codon_letters(nn[6*k +: 6]);
      end
      cod_bytes[47:0] = {cod_bytes[47:24], codon_letters(6'd0)};
      cod_bytes[23:0] = codon_letters(6'd0);
      msg_len = 8'd209 + {4'd0, cod_len} + {4'd0, blk_tag[3].nd};
      tail = '0;
      // Codon letters of the nonce come first.
      for (int j = 0; j < 15; j++) begin
         if (6'(j) < {2'b00, cod_len}) begin
            tail[407 - 8*j -: 8] = cod_bytes[119 - 8*j -: 8];
         end
      end
      // Then the separator, the decimal digits and the pad byte.
      for (int j = 0; j < 43; j++) begin
         off = 6'(j) - {2'b00, cod_len};
         m   = 4'(off - 6'd4);
         di  = 4'(blk_tag[3].nd - 4'd1 - m);
         if (6'(j) >= {2'b00, cod_len}) begin
            if (off < 6'd4) begin
               tail[407 - 8*j -: 8] = TAA_BAR[31 - 8*int'(off[1:0]) -: 8];
            end else if (off < 6'd4 + {2'b00, blk_tag[3].nd}) begin
               tail[407 - 8*j -: 8] = 8'h30 + {4'd0, blk_tag[3].digits[di[2:0]]};
            end else if (off == 6'd4 + {2'b00, blk_tag[3].nd}) begin
               tail[407 - 8*j -: 8] = 8'h80;
            end
         end
      end
      tail[63:0] = {53'd0, msg_len, 3'b000};
   end

   assign blk_msg[0] = prefix[1639 -: 512];
   assign blk_msg[1] = prefix[1127 -: 512];
   assign blk_msg[2] = prefix[615 -: 512];
   assign blk_msg[3] = {prefix[103:0], tail};

   assign blk_valid[0] = dec_valid[8];
   assign blk_tag[0]   = dec_data[8].tag;
   assign blk_hash[0]  = INIT_H;

   for (genvar b = 0; b < 4; b++) begin : g_block
      spn_block u_block (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (blk_valid[b]),
         .in_tag    (blk_tag[b]),
         .in_hash   (blk_hash[b]),
         .in_block  (blk_msg[b]),
         .out_valid (blk_valid[b+1]),
         .out_tag   (blk_tag[b+1]),
         .out_hash  (blk_hash[b+1])
      );
   end

   // Mask the digest and count leading zeros of each word.
   always_comb begin
      masked = blk_hash[4] ^ MIX_MASK;
      for (int k = 0; k < 8; k++) begin
         a_cnt_in[k] = 6'd32;
         for (int b = 0; b < 32; b++) begin
            if (masked[k][b]) begin
               a_cnt_in[k] = 6'(31 - b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= blk_valid[4];
      end
      if (en) begin
         a_nonce_ff <= blk_tag[4].nonce;
         a_cnt_ff   <= a_cnt_in;
      end
   end

   // Join the word counts up to the first word that is not zero.
   always_comb begin
      total = 9'd0;
      found = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (!found) begin
            total = total + {3'b000, a_cnt_ff[k]};
            if (a_cnt_ff[k] != 6'd32) begin
               found = 1'b1;
            end
         end
      end
      lts = total[8:1];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= a_valid_ff;
      end
      if (en) begin
         out_nonce_ff <= a_nonce_ff;
         out_lts_ff   <= lts;
         out_hit_ff   <= (lts >= {1'b0, target_ff});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_hit_ff, out_lts_ff, out_nonce_ff};

   `SPN_ASSERT(a_lts_range, clock, reset, rsp_tvalid |-> (rsp_tdata[31:24] <= 8'd128))
   `SPN_ASSERT(a_stall_cause, clock, reset, !req_tready |-> (rsp_tvalid && !rsp_tready))
   `SPN_ASSERT_ANY(a_reset_empty, clock, reset |=> !rsp_tvalid)
   `SPN_ASSERT(a_digit_count, clock, reset, blk_valid[3] |-> (blk_tag[3].nd != 4'd0 && blk_tag[3].nd <= 4'd8))
endmodule
